### rtl/core/mtaa_pkg.sv
// shared types and constants for the mesh triangle area accumulator
// no dependencies
package mtaa_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned D2_W    = 64;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned AREA_W  = 48;
  localparam int unsigned PROD_W  = 136;
  localparam int unsigned RAD_W   = 128;
  localparam int unsigned FACT_W  = 34;

  localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // one classified triangle: squared side lengths and long-side marks
  typedef struct packed {
    logic [2:0][D2_W-1:0] d2;
    logic [2:0]           sat;
    logic                 last;
  } tri_t;

endpackage

### rtl/core/mtaa_front.sv
// front end: accepts triangle beats and forms the three squared side lengths
// depends on mtaa_pkg
module mtaa_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  p0_x,
  input  logic signed [31:0]  p0_y,
  input  logic signed [31:0]  p0_z,
  input  logic signed [31:0]  p1_x,
  input  logic signed [31:0]  p1_y,
  input  logic signed [31:0]  p1_z,
  input  logic signed [31:0]  p2_x,
  input  logic signed [31:0]  p2_y,
  input  logic signed [31:0]  p2_z,
  input  logic                last_triangle,
  output logic                push_valid,
  input  logic                push_ready,
  output mtaa_pkg::tri_t      push_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0] state;
  logic [2:0][2:0][mtaa_pkg::COORD_W-1:0] pt;
  logic        last;
  logic [1:0]  side;
  logic [1:0]  axis;
  logic [64:0] sq;
  logic [65:0] sum;
  logic [2:0][mtaa_pkg::D2_W-1:0] d2;
  logic [2:0]  sat;

  logic [1:0]  u_idx;
  logic [1:0]  v_idx;
  logic [31:0] u_c;
  logic [31:0] v_c;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [65:0] sq_full;
  logic [65:0] sum_next;

  // vertex pair of each side
  always_comb begin
    case (side)
      2'd0: begin u_idx = 2'd0; v_idx = 2'd1; end
      2'd1: begin u_idx = 2'd0; v_idx = 2'd2; end
      default: begin u_idx = 2'd2; v_idx = 2'd1; end
    endcase
  end

  // coordinate difference and its square
  assign u_c      = pt[u_idx][axis];
  assign v_c      = pt[v_idx][axis];
  assign diff     = $signed({u_c[31], u_c}) - $signed({v_c[31], v_c});
  assign mag      = diff[32] ? 33'(-diff) : 33'(diff);
  assign sq_full  = {33'd0, mag} * {33'd0, mag};
  assign sum_next = sum + {1'b0, sq};

  assign in_ready   = (state == ST_IDLE);
  assign push_valid = (state == ST_PUSH);
  assign push_data  = '{d2: d2, sat: sat, last: last};

  // term sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      side  <= 2'd0;
      axis  <= 2'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pt[0] <= {p0_z, p0_y, p0_x};
            pt[1] <= {p1_z, p1_y, p1_x};
            pt[2] <= {p2_z, p2_y, p2_x};
            last  <= last_triangle;
            side  <= 2'd0;
            axis  <= 2'd0;
            sum   <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq    <= sq_full[64:0];
          state <= ST_ADD;
        end
        ST_ADD: begin
          if (axis == 2'd2) begin
            d2[side]  <= sum_next[63:0];
            sat[side] <= (sum_next[65:64] != 2'd0);
            sum       <= '0;
            axis      <= 2'd0;
            if (side == 2'd2) begin
              state <= ST_PUSH;
            end else begin
              side  <= side + 2'd1;
              state <= ST_SQ;
            end
          end else begin
            sum   <= sum_next;
            axis  <= axis + 2'd1;
            state <= ST_SQ;
          end
        end
        ST_PUSH: begin
          if (push_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/mtaa_queue.sv
// two-entry queue between front and back ends
// depends on mtaa_pkg
module mtaa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mtaa_pkg::tri_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mtaa_pkg::tri_t pop_data
);

  mtaa_pkg::tri_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/mtaa_back.sv
// back end: side roots, heron product, area root and saturating sum
// depends on mtaa_pkg
module mtaa_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  mtaa_pkg::tri_t pop_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [47:0]    total_area,
  output logic           area_saturated
);

  localparam int unsigned SH = 2 * FRAC_BITS + 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SIDE  = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_HERON = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_ACC   = 3'd5;

  logic [2:0] state;
  mtaa_pkg::tri_t item;
  logic [1:0] idx;
  logic [6:0] cnt;
  logic       area_mode;
  logic [2:0][mtaa_pkg::LEN_W-1:0]  len;
  logic [2:0][mtaa_pkg::FACT_W-1:0] fact;
  logic [mtaa_pkg::RAD_W-1:0]  rad;
  logic [65:0]                 rem;
  logic [63:0]                 root;
  logic [mtaa_pkg::PROD_W-1:0] mcand;
  logic [mtaa_pkg::PROD_W-1:0] prod;
  logic [mtaa_pkg::FACT_W-1:0] mplier;
  logic [63:0]                 tri_area;
  logic [47:0]                 area_sum;
  logic                        saturate_flag;

  logic [65:0] rem_t;
  logic [65:0] trial;
  logic        take;
  logic [33:0] s;
  logic [34:0] f1;
  logic [34:0] f2;
  logic [34:0] f3;
  logic        f_ok;
  logic [mtaa_pkg::PROD_W-1:0] prod_next;
  logic [mtaa_pkg::PROD_W-1:0] prod_sh;
  logic [47:0] t_clamp;
  logic        t_sat;
  logic [48:0] sum_wide;
  logic [47:0] sum_new;
  logic        sum_sat;
  logic        emit;

  // one step of the restoring square root
  assign rem_t = {rem[63:0], rad[mtaa_pkg::RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign take  = (rem_t >= trial);

  // half-perimeter factors (as doubled values)
  assign s    = {2'b00, len[0]} + {2'b00, len[1]} + {2'b00, len[2]};
  assign f1   = {1'b0, s} - {2'b00, len[0], 1'b0};
  assign f2   = {1'b0, s} - {2'b00, len[1], 1'b0};
  assign f3   = {1'b0, s} - {2'b00, len[2], 1'b0};
  assign f_ok = !f1[34] && (f1 != '0) && !f2[34] && (f2 != '0) &&
                !f3[34] && (f3 != '0);

  // shift-add multiply step and final scaling
  assign prod_next = {prod[mtaa_pkg::PROD_W-2:0], 1'b0} +
                     (mplier[mtaa_pkg::FACT_W-1] ? mcand : '0);
  assign prod_sh   = prod_next >> SH;

  // area clamp and saturating sum
  assign t_sat    = (tri_area[63:48] != 16'd0);
  assign t_clamp  = t_sat ? mtaa_pkg::AREA_MAX : tri_area[47:0];
  assign sum_wide = {1'b0, area_sum} + {1'b0, t_clamp};
  assign sum_sat  = sum_wide[48];
  assign sum_new  = sum_sat ? mtaa_pkg::AREA_MAX : sum_wide[47:0];

  // result beat leaves on the last triangle once the output register is free
  assign emit = (state == ST_ACC) && item.last && (!out_valid || out_ready);

  assign pop_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      area_sum      <= '0;
      saturate_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            item  <= pop_data;
            idx   <= 2'd0;
            state <= ST_SIDE;
          end
        end
        // start the root of one squared side, or saturate it
        ST_SIDE: begin
          if (item.sat[idx]) begin
            len[idx]      <= mtaa_pkg::LEN_MAX;
            saturate_flag <= 1'b1;
            if (idx == 2'd2) begin
              state <= ST_HERON;
            end else begin
              idx <= idx + 2'd1;
            end
          end else begin
            rad       <= {item.d2[idx], 64'd0};
            rem       <= '0;
            root      <= '0;
            cnt       <= 7'd31;
            area_mode <= 1'b0;
            state     <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          rad  <= {rad[mtaa_pkg::RAD_W-3:0], 2'b00};
          rem  <= take ? (rem_t - trial) : rem_t;
          root <= {root[62:0], take};
          cnt  <= cnt - 7'd1;
          if (cnt == 7'd0) begin
            if (area_mode) begin
              tri_area <= {root[62:0], take};
              state    <= ST_ACC;
            end else begin
              len[idx] <= {root[30:0], take};
              if (idx == 2'd2) begin
                state <= ST_HERON;
              end else begin
                idx   <= idx + 2'd1;
                state <= ST_SIDE;
              end
            end
          end
        end
        // load the heron factors and start the product, or add zero area for a degenerate triangle
        ST_HERON: begin
          if (f_ok) begin
            fact[0] <= f1[33:0];
            fact[1] <= f2[33:0];
            fact[2] <= f3[33:0];
            mcand   <= {{(mtaa_pkg::PROD_W-34){1'b0}}, s};
            prod    <= '0;
            mplier  <= f1[33:0];
            idx     <= 2'd0;
            cnt     <= 7'(mtaa_pkg::FACT_W - 1);
            state   <= ST_MUL;
          end else begin
            tri_area <= '0;
            state    <= ST_ACC;
          end
        end
        ST_MUL: begin
          if (cnt == 7'd0) begin
            prod <= '0;
            if (idx == 2'd2) begin
              rad       <= prod_sh[mtaa_pkg::RAD_W-1:0];
              rem       <= '0;
              root      <= '0;
              cnt       <= 7'd63;
              area_mode <= 1'b1;
              state     <= ST_ROOT;
            end else begin
              mcand  <= prod_next;
              mplier <= fact[idx + 2'd1];
              idx    <= idx + 2'd1;
              cnt    <= 7'(mtaa_pkg::FACT_W - 1);
            end
          end else begin
            mplier <= {mplier[mtaa_pkg::FACT_W-2:0], 1'b0};
            prod   <= prod_next;
            cnt    <= cnt - 7'd1;
          end
        end
        // add the area, emit on the last triangle
        ST_ACC: begin
          if (item.last) begin
            if (emit) begin
              total_area     <= sum_new;
              area_saturated <= saturate_flag || t_sat || sum_sat;
              area_sum       <= '0;
              saturate_flag  <= 1'b0;
              state          <= ST_IDLE;
            end
          end else begin
            area_sum      <= sum_new;
            saturate_flag <= saturate_flag || t_sat || sum_sat;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/mesh_triangle_area_accumulator_core.sv
// heron triangle area sum: front end, queue and back end
// each triangle passes through the front end, the queue and the back end in turn;
// a saturated side skips its root, a degenerate triangle the product and area root
// the back end takes a new triangle only once done with the last, as the shared
// bit-serial root and the shift-add multiply unit work through it step by step
// reset clears the running sum, the saturation flag, the queue and the output valid
module mesh_triangle_area_accumulator_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] p0_x,
  input  logic signed [31:0] p0_y,
  input  logic signed [31:0] p0_z,
  input  logic signed [31:0] p1_x,
  input  logic signed [31:0] p1_y,
  input  logic signed [31:0] p1_z,
  input  logic signed [31:0] p2_x,
  input  logic signed [31:0] p2_y,
  input  logic signed [31:0] p2_z,
  input  logic               last_triangle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [47:0]        total_area,
  output logic               area_saturated
);

  logic           push_valid;
  logic           push_ready;
  mtaa_pkg::tri_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  mtaa_pkg::tri_t pop_data;

  // squared side lengths
  mtaa_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
    .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
    .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
    .last_triangle(last_triangle),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  // decoupling queue
  mtaa_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  // roots, product and sum
  mtaa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .total_area(total_area), .area_saturated(area_saturated)
  );

endmodule
